// ===== hdl/vna_pkg.sv =====
// ----------------------------------------------------------------------------
// vna_pkg
// Shared types and constants for the vertex normal accumulator.
// ----------------------------------------------------------------------------
package vna_pkg;

    localparam int VertexCount = 1024;
    localparam int IndexWidth  = $clog2(VertexCount);
    localparam int CoordWidth  = 32;
    localparam int NormalWidth = 16;
    localparam int NormOneBit  = NormalWidth - 2;

    typedef enum logic [1:0] {
        MODE_LOAD = 2'd0,
        MODE_TRI  = 2'd1,
        MODE_READ = 2'd2,
        MODE_NONE = 2'd3
    } mode_t;

    typedef struct packed {
        logic [1:0]                   mode;
        logic [9:0]                   index_a;
        logic [9:0]                   index_b;
        logic [9:0]                   index_c;
        logic signed [CoordWidth-1:0] pos_x;
        logic signed [CoordWidth-1:0] pos_y;
        logic signed [CoordWidth-1:0] pos_z;
    } vna_in_t;

    typedef struct packed {
        logic [9:0]                    read_index;
        logic signed [NormalWidth-1:0] normal_x;
        logic signed [NormalWidth-1:0] normal_y;
        logic signed [NormalWidth-1:0] normal_z;
    } vna_out_t;

endpackage

// ===== hdl/vertex_normal_accumulate.sv =====
// ----------------------------------------------------------------------------
// vertex_normal_accumulate
// Vertex position store and smooth per-vertex normal accumulator.
// ----------------------------------------------------------------------------
// A load beat is written to the position store as it is taken and leaves the
// block idle, so loads can follow back to back. A read beat keeps s_ready low
// while the normal store is read and its result beat is formed, and then for
// as long as that result beat waits to be taken. A triangle beat first fetches
// the three corner positions, then reduces the edges and forms the cross
// product. Then come four normalisations: the face normal, and the sum at each
// corner, which adds a read and a write-back per corner. Each normalisation
// runs on one shared sequencer: a bit-serial square root and three restoring
// divides, with the squares and the cross product formed one product per cycle
// on a single 32x32 multiplier. A zero-length vector skips the root and the
// divides. After reset the block sweeps the normal store to zero, during which
// s_ready stays low. One beat is worked on at a time; s_ready is low while it
// is in progress.
module vertex_normal_accumulate
    import vna_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  vna_in_t  s_data,
    output logic     m_valid,
    input  logic     m_ready,
    output vna_out_t m_data
);

    localparam int NW = NormalWidth;
    localparam int IW = IndexWidth;

    typedef enum logic [4:0] {
        ST_CLEAR, ST_IDLE, ST_RD_WAIT, ST_RD_OUT, ST_POS_ADDR, ST_POS_WAIT,
        ST_POS_GET, ST_EDGE, ST_REDUCE, ST_CROSS, ST_NORM_MAX, ST_NORM_SHIFT,
        ST_NORM_SQ, ST_SQRT, ST_DIV, ST_NORM_DONE, ST_ACC_ADDR, ST_ACC_WAIT,
        ST_ACC_SUM, ST_ACC_WRITE
    } state_t;

    state_t state_reg;

    // Stores
    logic            pos_we, nrm_we;
    logic [IW-1:0]   pos_wa, pos_ra, nrm_wa, nrm_ra;
    logic [CoordWidth-1:0] xw, yw, zw, xr, yr, zr;
    logic [NW-1:0]   nxw, nyw, nzw, nxr, nyr, nzr;

    vna_ram #(.WIDTH(CoordWidth), .DEPTH(VertexCount)) u_x (
        .aclk, .wr_en(pos_we), .wr_addr(pos_wa), .wr_data(xw), .rd_addr(pos_ra), .rd_data(xr));
    vna_ram #(.WIDTH(CoordWidth), .DEPTH(VertexCount)) u_y (
        .aclk, .wr_en(pos_we), .wr_addr(pos_wa), .wr_data(yw), .rd_addr(pos_ra), .rd_data(yr));
    vna_ram #(.WIDTH(CoordWidth), .DEPTH(VertexCount)) u_z (
        .aclk, .wr_en(pos_we), .wr_addr(pos_wa), .wr_data(zw), .rd_addr(pos_ra), .rd_data(zr));
    vna_ram #(.WIDTH(NW), .DEPTH(VertexCount)) u_nx (
        .aclk, .wr_en(nrm_we), .wr_addr(nrm_wa), .wr_data(nxw), .rd_addr(nrm_ra), .rd_data(nxr));
    vna_ram #(.WIDTH(NW), .DEPTH(VertexCount)) u_ny (
        .aclk, .wr_en(nrm_we), .wr_addr(nrm_wa), .wr_data(nyw), .rd_addr(nrm_ra), .rd_data(nyr));
    vna_ram #(.WIDTH(NW), .DEPTH(VertexCount)) u_nz (
        .aclk, .wr_en(nrm_we), .wr_addr(nrm_wa), .wr_data(nzw), .rd_addr(nrm_ra), .rd_data(nzr));

    // Working registers
    vna_in_t         in_reg;
    logic [IW-1:0]   clr_reg;
    logic [1:0]      cnt_reg;          // corner or product counter
    logic [2:0]      sub_reg;          // product step within cross product
    logic signed [CoordWidth:0] pa_reg [3];   // corner A position
    logic signed [CoordWidth:0] e1_reg [3];
    logic signed [CoordWidth:0] e2_reg [3];
    logic [30:0]     r1_reg [3];       // reduced edge magnitudes
    logic [30:0]     r2_reg [3];
    logic            s1_reg [3];
    logic            s2_reg [3];
    logic signed [63:0] cr_reg [3];
    logic signed [63:0] prod_reg;
    // Normaliser
    logic [62:0]     vm_reg [3];       // component magnitudes
    logic            vs_reg [3];       // component signs
    logic [5:0]      p_reg;
    logic [19:0]     sm_reg [3];       // scaled magnitudes
    logic [41:0]     sum_reg;          // sum of squares
    logic [41:0]     rem_reg;
    logic [20:0]     root_reg;
    logic [4:0]      it_reg;
    logic [NW-1:0]   q_reg [3];
    logic [37:0]     dnum_reg;
    logic [21:0]     drem_reg;
    logic            is_face_reg;
    logic signed [NW-1:0] face_reg [3];
    logic [1:0]      corner_reg;
    logic [IW-1:0]   cidx_reg;
    vna_out_t        out_reg;
    logic            m_valid_reg;

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

    // Shared multiplier: one signed 32x32 product per cycle
    logic signed [31:0] mul_a, mul_b;
    logic signed [63:0] mul_p;
    assign mul_p = 64'(mul_a) * 64'(mul_b);

    // Reduced edge signed operand
    function automatic logic signed [31:0] sgn(input logic [30:0] m, input logic s);
        logic signed [31:0] v;
        v = $signed({1'b0, m});
        return s ? -v : v;
    endfunction

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        if (state_reg == ST_CROSS) begin
            unique case (sub_reg)
                3'd0: begin mul_a = sgn(r1_reg[1], s1_reg[1]); mul_b = sgn(r2_reg[2], s2_reg[2]); end
                3'd1: begin mul_a = sgn(r1_reg[2], s1_reg[2]); mul_b = sgn(r2_reg[1], s2_reg[1]); end
                3'd2: begin mul_a = sgn(r1_reg[2], s1_reg[2]); mul_b = sgn(r2_reg[0], s2_reg[0]); end
                3'd3: begin mul_a = sgn(r1_reg[0], s1_reg[0]); mul_b = sgn(r2_reg[2], s2_reg[2]); end
                3'd4: begin mul_a = sgn(r1_reg[0], s1_reg[0]); mul_b = sgn(r2_reg[1], s2_reg[1]); end
                3'd5: begin mul_a = sgn(r1_reg[1], s1_reg[1]); mul_b = sgn(r2_reg[0], s2_reg[0]); end
                default: begin mul_a = '0; mul_b = '0; end
            endcase
        end else if (state_reg == ST_NORM_SQ) begin
            mul_a = $signed({12'd0, sm_reg[cnt_reg]});
            mul_b = $signed({12'd0, sm_reg[cnt_reg]});
        end
    end

    // Magnitude helpers
    function automatic logic [62:0] mag64(input logic signed [63:0] v);
        logic [63:0] u;
        u = v[63] ? (~v + 64'd1) : v;
        return u[62:0];
    endfunction
    function automatic logic [31:0] mag33(input logic signed [32:0] v);
        logic [32:0] u;
        u = v[32] ? (~v + 33'd1) : v;
        return u[31:0];
    endfunction

    // OR of the three magnitudes and its top set bit (that of the largest one)
    logic [62:0] vmax;
    logic [5:0]  top;
    always_comb begin
        vmax = vm_reg[0] | vm_reg[1] | vm_reg[2];
        top  = '0;
        for (int i = 0; i < 63; i++) begin
            if (vmax[i]) top = 6'(i);
        end
    end

    // Square-root step (two bits of radicand per cycle)
    logic [43:0] sq_trial;
    logic [41:0] sq_rem_sh;
    always_comb begin
        sq_rem_sh = {rem_reg[39:0], sum_reg[41:40]};
        sq_trial  = {2'b0, sq_rem_sh} - {21'd0, root_reg, 2'b01};
    end

    // Divide step: quotient of (2*m*ONE + L) by 2L, one bit per cycle
    logic [23:0] dv_trial;
    logic [22:0] dv_sh;
    always_comb begin
        dv_sh    = {drem_reg, dnum_reg[37]};
        dv_trial = {1'b0, dv_sh} - {2'b0, root_reg, 1'b0};
    end

    logic signed [NW:0] acc_sum [3];
    always_comb begin
        acc_sum[0] = {nxr[NW-1], nxr} + {face_reg[0][NW-1], face_reg[0]};
        acc_sum[1] = {nyr[NW-1], nyr} + {face_reg[1][NW-1], face_reg[1]};
        acc_sum[2] = {nzr[NW-1], nzr} + {face_reg[2][NW-1], face_reg[2]};
    end

    logic [IW-1:0] corner_idx;
    always_comb begin
        unique case (corner_reg)
            2'd0:    corner_idx = in_reg.index_a;
            2'd1:    corner_idx = in_reg.index_b;
            default: corner_idx = in_reg.index_c;
        endcase
    end

    // Store port drive
    always_comb begin
        pos_we = (state_reg == ST_IDLE) && s_valid && (s_data.mode == MODE_LOAD);
        pos_wa = s_data.index_a;
        xw = s_data.pos_x;
        yw = s_data.pos_y;
        zw = s_data.pos_z;
        nrm_we = 1'b0;
        nrm_wa = cidx_reg;
        nxw = '0; nyw = '0; nzw = '0;
        if (state_reg == ST_CLEAR) begin
            nrm_we = 1'b1;
            nrm_wa = clr_reg;
        end else if (pos_we) begin
            nrm_we = 1'b1;
            nrm_wa = s_data.index_a;
        end else if (state_reg == ST_ACC_WRITE) begin
            nrm_we = 1'b1;
            nxw = vs_reg[0] ? -q_reg[0] : q_reg[0];
            nyw = vs_reg[1] ? -q_reg[1] : q_reg[1];
            nzw = vs_reg[2] ? -q_reg[2] : q_reg[2];
        end
        unique case (cnt_reg)
            2'd0:    pos_ra = in_reg.index_a;
            2'd1:    pos_ra = in_reg.index_b;
            default: pos_ra = in_reg.index_c;
        endcase
        nrm_ra = (state_reg == ST_RD_WAIT) ? in_reg.index_a : corner_idx;
    end

    // Sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            clr_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            unique case (state_reg)
                ST_CLEAR: begin
                    clr_reg <= clr_reg + 1'b1;
                    if (clr_reg == IW'(VertexCount - 1)) state_reg <= ST_IDLE;
                end
                ST_IDLE: begin
                    if (s_valid) begin
                        in_reg <= s_data;
                        cnt_reg <= '0;
                        unique case (s_data.mode)
                            MODE_TRI:  state_reg <= ST_POS_ADDR;
                            MODE_READ: state_reg <= ST_RD_WAIT;
                            default:   state_reg <= ST_IDLE;
                        endcase
                    end
                end
                ST_RD_WAIT: state_reg <= ST_RD_OUT;
                ST_RD_OUT: begin
                    if (!m_valid_reg) begin
                        out_reg <= '{read_index: in_reg.index_a, normal_x: nxr,
                                     normal_y: nyr, normal_z: nzr};
                        m_valid_reg <= 1'b1;
                    end else if (m_ready) begin
                        m_valid_reg <= 1'b0;
                        state_reg <= ST_IDLE;
                    end
                end
                // Fetch positions of the three corners in turn
                ST_POS_ADDR: state_reg <= ST_POS_WAIT;
                ST_POS_WAIT: state_reg <= ST_POS_GET;
                ST_POS_GET: begin
                    if (cnt_reg == 2'd0) begin
                        pa_reg[0] <= {xr[31], xr};
                        pa_reg[1] <= {yr[31], yr};
                        pa_reg[2] <= {zr[31], zr};
                    end else if (cnt_reg == 2'd1) begin
                        e1_reg[0] <= {xr[31], xr};
                        e1_reg[1] <= {yr[31], yr};
                        e1_reg[2] <= {zr[31], zr};
                    end else begin
                        e2_reg[0] <= {xr[31], xr};
                        e2_reg[1] <= {yr[31], yr};
                        e2_reg[2] <= {zr[31], zr};
                    end
                    if (cnt_reg == 2'd2) state_reg <= ST_EDGE;
                    else begin
                        cnt_reg <= cnt_reg + 2'd1;
                        state_reg <= ST_POS_ADDR;
                    end
                end
                ST_EDGE: begin
                    for (int i = 0; i < 3; i++) begin
                        logic signed [32:0] d1, d2;
                        logic [31:0] m1, m2;
                        d1 = e1_reg[i] - pa_reg[i];
                        d2 = e2_reg[i] - pa_reg[i];
                        m1 = mag33(d1);
                        m2 = mag33(d2);
                        s1_reg[i] <= d1[32];
                        s2_reg[i] <= d2[32];
                        // full magnitudes are kept until the first reduction step
                        r1_reg[i] <= m1[30:0];
                        r2_reg[i] <= m2[30:0];
                        e1_reg[i] <= {1'b0, m1};
                        e2_reg[i] <= {1'b0, m2};
                    end
                    state_reg <= ST_REDUCE;
                end
                ST_REDUCE: begin
                    // Each edge is halved as a whole. An edge with a magnitude
                    // of 2^31 or more first halves all three components from
                    // the full magnitudes; single halvings follow while any
                    // component still reaches 2^30.
                    if (e1_reg[0][31] | e1_reg[1][31] | e1_reg[2][31] ||
                        e2_reg[0][31] | e2_reg[1][31] | e2_reg[2][31]) begin
                        for (int i = 0; i < 3; i++) begin
                            e1_reg[i][31] <= 1'b0;
                            e2_reg[i][31] <= 1'b0;
                            if (e1_reg[0][31] | e1_reg[1][31] | e1_reg[2][31])
                                r1_reg[i] <= e1_reg[i][31:1];
                            if (e2_reg[0][31] | e2_reg[1][31] | e2_reg[2][31])
                                r2_reg[i] <= e2_reg[i][31:1];
                        end
                    end else if (r1_reg[0][30] | r1_reg[1][30] | r1_reg[2][30]) begin
                        for (int i = 0; i < 3; i++) r1_reg[i] <= r1_reg[i] >> 1;
                    end else if (r2_reg[0][30] | r2_reg[1][30] | r2_reg[2][30]) begin
                        for (int i = 0; i < 3; i++) r2_reg[i] <= r2_reg[i] >> 1;
                    end else begin
                        sub_reg <= '0;
                        state_reg <= ST_CROSS;
                    end
                end
                // Cross product, one product per cycle
                ST_CROSS: begin
                    sub_reg <= sub_reg + 3'd1;
                    if (!sub_reg[0]) prod_reg <= mul_p;
                    else cr_reg[sub_reg[2:1]] <= prod_reg - mul_p;
                    if (sub_reg == 3'd5) begin
                        is_face_reg <= 1'b1;
                        state_reg <= ST_NORM_MAX;
                    end
                    if (sub_reg == 3'd5) begin
                        for (int i = 0; i < 3; i++) begin
                            logic signed [63:0] cv;
                            cv = (i == 2) ? (prod_reg - mul_p) : cr_reg[i];
                            vm_reg[i] <= mag64(cv);
                            vs_reg[i] <= cv[63];
                        end
                    end
                end
                ST_NORM_MAX: begin
                    p_reg <= top;
                    if (vmax == '0) begin
                        for (int i = 0; i < 3; i++) q_reg[i] <= '0;
                        state_reg <= ST_NORM_DONE;
                    end else state_reg <= ST_NORM_SHIFT;
                end
                ST_NORM_SHIFT: begin
                    for (int i = 0; i < 3; i++) begin
                        sm_reg[i] <= (p_reg > 6'd19) ? 20'(vm_reg[i] >> (p_reg - 6'd19))
                                                     : 20'(vm_reg[i] << (6'd19 - p_reg));
                    end
                    sum_reg <= '0;
                    cnt_reg <= '0;
                    state_reg <= ST_NORM_SQ;
                end
                ST_NORM_SQ: begin
                    sum_reg <= sum_reg + mul_p[41:0];
                    if (cnt_reg == 2'd2) begin
                        rem_reg <= '0;
                        root_reg <= '0;
                        it_reg <= '0;
                        state_reg <= ST_SQRT;
                    end else cnt_reg <= cnt_reg + 2'd1;
                end
                ST_SQRT: begin
                    sum_reg <= {sum_reg[39:0], 2'b00};
                    if (!sq_trial[43]) begin
                        rem_reg <= sq_trial[41:0];
                        root_reg <= {root_reg[19:0], 1'b1};
                    end else begin
                        rem_reg <= sq_rem_sh;
                        root_reg <= {root_reg[19:0], 1'b0};
                    end
                    it_reg <= it_reg + 5'd1;
                    if (it_reg == 5'd20) begin
                        cnt_reg <= '0;
                        it_reg <= '0;
                        drem_reg <= '0;
                        state_reg <= ST_DIV;
                    end
                end
                ST_DIV: begin
                    logic [37:0] num_full;
                    num_full = '0;
                    if (it_reg == 5'd0) begin
                        // Numerator 2*m*ONE + L. The quotient never needs more
                        // than 15 bits, so the numerator's upper bits seed the
                        // remainder and only its low 15 bits are shifted in.
                        num_full = ({18'd0, sm_reg[cnt_reg]} << (NormOneBit + 1))
                                   + {17'd0, root_reg};
                        dnum_reg <= {num_full[14:0], 23'd0};
                        drem_reg <= num_full[36:15];
                        q_reg[cnt_reg] <= '0;
                        it_reg <= 5'd1;
                    end else begin
                        dnum_reg <= {dnum_reg[36:0], 1'b0};
                        if (!dv_trial[23]) begin
                            drem_reg <= dv_trial[21:0];
                            q_reg[cnt_reg] <= {q_reg[cnt_reg][NW-2:0], 1'b1};
                        end else begin
                            drem_reg <= dv_sh[21:0];
                            q_reg[cnt_reg] <= {q_reg[cnt_reg][NW-2:0], 1'b0};
                        end
                        if (it_reg == 5'd15) begin
                            it_reg <= '0;
                            if (cnt_reg == 2'd2) state_reg <= ST_NORM_DONE;
                            else cnt_reg <= cnt_reg + 2'd1;
                        end else it_reg <= it_reg + 5'd1;
                    end
                end
                ST_NORM_DONE: begin
                    if (is_face_reg) begin
                        for (int i = 0; i < 3; i++)
                            face_reg[i] <= vs_reg[i] ? -q_reg[i] : q_reg[i];
                        is_face_reg <= 1'b0;
                        corner_reg <= '0;
                        state_reg <= ST_ACC_ADDR;
                    end else state_reg <= ST_ACC_WRITE;
                end
                ST_ACC_ADDR: begin
                    cidx_reg <= corner_idx;
                    state_reg <= ST_ACC_WAIT;
                end
                ST_ACC_WAIT: state_reg <= ST_ACC_SUM;
                ST_ACC_SUM: begin
                    for (int i = 0; i < 3; i++) begin
                        logic [NW:0] am;
                        am = acc_sum[i][NW] ? (~acc_sum[i] + 1'b1) : acc_sum[i];
                        vm_reg[i] <= 63'(am);
                        vs_reg[i] <= acc_sum[i][NW];
                    end
                    state_reg <= ST_NORM_MAX;
                end
                ST_ACC_WRITE: begin
                    if (corner_reg == 2'd2) state_reg <= ST_IDLE;
                    else begin
                        corner_reg <= corner_reg + 2'd1;
                        state_reg <= ST_ACC_ADDR;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

endmodule

// ===== hdl/vna_ram.sv =====
// ----------------------------------------------------------------------------
// vna_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ----------------------------------------------------------------------------
module vna_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write and one registered read per cycle.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

// ===== hdl/vna_checker.sv =====
// ----------------------------------------------------------------------------
// vna_checker
// Port-level checks on the vertex normal accumulator, bound to the top level.
// ----------------------------------------------------------------------------
module vna_checker
    import vna_pkg::*;
(
    input logic     aclk,
    input logic     aresetn,
    input logic     s_valid,
    input logic     s_ready,
    input vna_in_t  s_data,
    input logic     m_valid,
    input logic     m_ready,
    input vna_out_t m_data
);

    // A result beat holds until it is taken.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result beat changed while stalled");

    // No new input beat is taken while a result waits.
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !s_ready)
        else $error("input taken while result pending");

    // After a read beat the block is busy for the next cycle of work.
    a_after: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_data.mode == MODE_READ |=> !s_ready)
        else $error("read beat did not occupy the block");

    // The x component of a normal never exceeds one in magnitude.
    a_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.normal_x <= 16'sd16384 && m_data.normal_x >= -16'sd16384))
        else $error("normal component out of range");

endmodule

bind vertex_normal_accumulate vna_checker u_vna_checker (.*);

// ===== bench/vertex_normal_accumulate_tb.sv =====
// ----------------------------------------------------------------------------
// vertex_normal_accumulate_tb
// Self-checking bench for the vertex normal accumulator. A directed sequence
// covers the coordinate extremes, every mode, flat and repeated-corner
// triangles and normals that cancel to zero. Random loads, triangles and
// reads follow. Accepted beats feed a fixed-point predictor, and every result
// beat is checked field by field against the oldest predicted normal.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module vertex_normal_accumulate_tb
    import vna_pkg::*;
();

    localparam int RandomItems = 1300;
    localparam int CalmTail    = 150;
    localparam longint unsigned NormOne = 64'd1 << NormOneBit;

    logic     aclk;
    logic     aresetn;
    logic     s_valid;
    logic     s_ready;
    vna_in_t  s_data;
    logic     m_valid;
    logic     m_ready;
    vna_out_t m_data;

    vna_in_t  pending_beats[$];
    vna_out_t expected_normals[$];

    // Predictor state: positions and accumulated normals per vertex.
    longint pos_x_mem[VertexCount];
    longint pos_y_mem[VertexCount];
    longint pos_z_mem[VertexCount];
    longint nrm_x_mem[VertexCount];
    longint nrm_y_mem[VertexCount];
    longint nrm_z_mem[VertexCount];

    // Which vertices the stimulus has loaded, so triangles only use those.
    bit loaded[VertexCount];
    int loaded_list[$];

    int error_count  = 0;
    int load_count   = 0;
    int tri_count    = 0;
    int read_count   = 0;
    int other_count  = 0;
    int result_count = 0;
    int send_idle;
    int recv_idle;

    vertex_normal_accumulate i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic longint unsigned abs_val(input longint v);
        return v < 0 ? longint'(-v) : longint'(v);
    endfunction

    function automatic longint unsigned floor_sqrt(input longint unsigned s);
        longint unsigned root;
        longint unsigned bitpos;
        root = 0;
        bitpos = 64'd1 << 62;
        while (bitpos > s) bitpos >>= 2;
        while (bitpos != 0) begin
            if (s >= root + bitpos) begin
                s -= root + bitpos;
                root = (root >> 1) + bitpos;
            end else begin
                root >>= 1;
            end
            bitpos >>= 2;
        end
        return root;
    endfunction

    // Scale the vector so its largest magnitude sits in [2^19, 2^20), then
    // divide each magnitude by the length, rounding halves away from zero.
    task automatic unit_vector(input longint v[3], output longint r[3]);
        longint unsigned m[3];
        longint unsigned top;
        longint unsigned sq;
        longint unsigned len;
        longint unsigned q;
        int p;
        top = 0;
        sq = 0;
        p = 0;
        for (int i = 0; i < 3; i++) begin
            m[i] = abs_val(v[i]);
            if (m[i] > top) top = m[i];
        end
        if (top == 0) begin
            r[0] = 0;
            r[1] = 0;
            r[2] = 0;
            return;
        end
        while (p < 63 && (top >> (p + 1)) != 0) p++;
        for (int i = 0; i < 3; i++) begin
            m[i] = p > 19 ? m[i] >> (p - 19) : m[i] << (19 - p);
            sq += m[i] * m[i];
        end
        len = floor_sqrt(sq);
        for (int i = 0; i < 3; i++) begin
            q = (2 * m[i] * NormOne + len) / (2 * len);
            r[i] = v[i] < 0 ? -longint'(q) : longint'(q);
        end
    endtask

    // Halve all edge magnitudes together until each is below 2^30.
    task automatic shrink_edge(inout longint e[3]);
        longint unsigned m[3];
        for (int i = 0; i < 3; i++) m[i] = abs_val(e[i]);
        while (m[0] >= (64'd1 << 30) || m[1] >= (64'd1 << 30) || m[2] >= (64'd1 << 30))
            for (int i = 0; i < 3; i++) m[i] >>= 1;
        for (int i = 0; i < 3; i++) e[i] = e[i] < 0 ? -longint'(m[i]) : longint'(m[i]);
    endtask

    task automatic add_face(input int k, input longint face[3]);
        longint sum[3];
        longint n[3];
        sum[0] = nrm_x_mem[k] + face[0];
        sum[1] = nrm_y_mem[k] + face[1];
        sum[2] = nrm_z_mem[k] + face[2];
        unit_vector(sum, n);
        nrm_x_mem[k] = n[0];
        nrm_y_mem[k] = n[1];
        nrm_z_mem[k] = n[2];
    endtask

    // Update the predicted stores for one accepted beat.
    task automatic predict_beat(input vna_in_t b);
        longint e1[3];
        longint e2[3];
        longint cr[3];
        longint face[3];
        int a;
        int bb;
        int c;
        vna_out_t res;
        a = int'(b.index_a);
        bb = int'(b.index_b);
        c = int'(b.index_c);
        case (mode_t'(b.mode))
            MODE_LOAD: begin
                pos_x_mem[a] = longint'(b.pos_x);
                pos_y_mem[a] = longint'(b.pos_y);
                pos_z_mem[a] = longint'(b.pos_z);
                nrm_x_mem[a] = 0;
                nrm_y_mem[a] = 0;
                nrm_z_mem[a] = 0;
                load_count++;
            end
            MODE_TRI: begin
                e1[0] = pos_x_mem[bb] - pos_x_mem[a];
                e1[1] = pos_y_mem[bb] - pos_y_mem[a];
                e1[2] = pos_z_mem[bb] - pos_z_mem[a];
                e2[0] = pos_x_mem[c] - pos_x_mem[a];
                e2[1] = pos_y_mem[c] - pos_y_mem[a];
                e2[2] = pos_z_mem[c] - pos_z_mem[a];
                shrink_edge(e1);
                shrink_edge(e2);
                cr[0] = e1[1] * e2[2] - e1[2] * e2[1];
                cr[1] = e1[2] * e2[0] - e1[0] * e2[2];
                cr[2] = e1[0] * e2[1] - e1[1] * e2[0];
                unit_vector(cr, face);
                add_face(a, face);
                add_face(bb, face);
                add_face(c, face);
                tri_count++;
            end
            MODE_READ: begin
                res.read_index = b.index_a;
                res.normal_x = nrm_x_mem[a][NormalWidth-1:0];
                res.normal_y = nrm_y_mem[a][NormalWidth-1:0];
                res.normal_z = nrm_z_mem[a][NormalWidth-1:0];
                expected_normals = {expected_normals, res};
                read_count++;
            end
            default: other_count++;
        endcase
    endtask

    // Stimulus builders; unused fields carry random bits.
    function automatic vna_in_t noise_beat(input mode_t m);
        vna_in_t b;
        b.mode = m;
        b.index_a = 10'($urandom);
        b.index_b = 10'($urandom);
        b.index_c = 10'($urandom);
        b.pos_x = $urandom;
        b.pos_y = $urandom;
        b.pos_z = $urandom;
        return b;
    endfunction

    task automatic queue_load(input int idx, input logic [31:0] x, input logic [31:0] y,
                              input logic [31:0] z);
        vna_in_t b;
        b = noise_beat(MODE_LOAD);
        b.index_a = 10'(idx);
        b.pos_x = x;
        b.pos_y = y;
        b.pos_z = z;
        if (!loaded[idx]) loaded_list = {loaded_list, idx};
        loaded[idx] = 1'b1;
        pending_beats = {pending_beats, b};
    endtask

    task automatic queue_tri(input int a, input int b2, input int c);
        vna_in_t b;
        b = noise_beat(MODE_TRI);
        b.index_a = 10'(a);
        b.index_b = 10'(b2);
        b.index_c = 10'(c);
        pending_beats = {pending_beats, b};
    endtask

    task automatic queue_read(input int idx);
        vna_in_t b;
        b = noise_beat(MODE_READ);
        b.index_a = 10'(idx);
        pending_beats = {pending_beats, b};
    endtask

    task automatic queue_ignored();
        vna_in_t b;
        b = noise_beat(MODE_NONE);
        pending_beats = {pending_beats, b};
    endtask

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(0, 3))
            0: return $urandom;
            1: return $urandom_range(0, 32'h000F_FFFF) - 32'h0008_0000;
            2: return $urandom_range(0, 255) << 16;
            default: return $urandom_range(0, 32'h0000_FFFF);
        endcase
    endfunction

    function automatic int pick_loaded();
        return loaded_list[$urandom_range(0, loaded_list.size() - 1)];
    endfunction

    initial begin
        int sel;
        // Directed part: unit axes, cancelling faces, flat and repeated corners.
        queue_read(0);
        queue_load(10, 32'd0, 32'd0, 32'd0);
        queue_load(11, 32'h0001_0000, 32'd0, 32'd0);
        queue_load(12, 32'd0, 32'h0001_0000, 32'd0);
        queue_load(13, 32'h0002_0000, 32'd0, 32'd0);
        queue_tri(10, 11, 12);
        queue_read(10);
        queue_tri(10, 12, 11);
        queue_read(10);
        queue_read(11);
        queue_tri(10, 11, 13);
        queue_read(13);
        queue_tri(11, 11, 12);
        queue_read(11);
        // Coordinate extremes and the top and bottom indices.
        queue_load(0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
        queue_load(1023, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
        queue_load(512, 32'hFFFF_FFFF, 32'h0000_0001, 32'h8000_0000);
        queue_tri(0, 1023, 512);
        queue_tri(1023, 512, 0);
        queue_read(0);
        queue_read(1023);
        queue_read(512);
        queue_ignored();
        queue_read(12);

        // Random part: mostly loads and triangles over loaded vertices.
        for (int n = 0; n < RandomItems; n++) begin
            sel = $urandom_range(0, 99);
            if (sel < 28 || loaded_list.size() < 3)
                queue_load(loaded_list.size() < 200 ? $urandom_range(0, 1023) : pick_loaded(),
                           rand_coord(), rand_coord(), rand_coord());
            else if (sel < 65)
                queue_tri(pick_loaded(), pick_loaded(), pick_loaded());
            else if (sel < 95)
                queue_read($urandom_range(0, 3) == 0 ? $urandom_range(0, 1023) : pick_loaded());
            else
                queue_ignored();
        end
    end

    // Driver: present beats from the queue, with random gaps.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid   <= 1'b0;
            s_data    <= '0;
            send_idle <= 0;
        end else if (!s_valid || s_ready) begin
            if (s_valid) predict_beat(s_data);
            if (send_idle > 0) begin
                s_valid   <= 1'b0;
                send_idle <= send_idle - 1;
            end else if (pending_beats.size() > 0) begin
                s_valid <= 1'b1;
                s_data  <= pending_beats.pop_front();
                if (pending_beats.size() > CalmTail && $urandom_range(0, 5) == 0)
                    send_idle <= $urandom_range(1, 4);
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Monitor: check result beats and apply random back-pressure.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready   <= 1'b0;
            recv_idle <= 0;
        end else begin
            if (m_valid && m_ready) begin
                result_count++;
                if (expected_normals.size() == 0) begin
                    $display("%0t: unexpected result beat %p", $time, m_data);
                    error_count++;
                end else begin
                    vna_out_t want;
                    want = expected_normals.pop_front();
                    if (m_data.read_index !== want.read_index) begin
                        $display("%0t: read_index expected %0d, got %0d", $time,
                                 want.read_index, m_data.read_index);
                        error_count++;
                    end
                    if (m_data.normal_x !== want.normal_x) begin
                        $display("%0t: normal_x at %0d expected %0d, got %0d", $time,
                                 want.read_index, want.normal_x, m_data.normal_x);
                        error_count++;
                    end
                    if (m_data.normal_y !== want.normal_y) begin
                        $display("%0t: normal_y at %0d expected %0d, got %0d", $time,
                                 want.read_index, want.normal_y, m_data.normal_y);
                        error_count++;
                    end
                    if (m_data.normal_z !== want.normal_z) begin
                        $display("%0t: normal_z at %0d expected %0d, got %0d", $time,
                                 want.read_index, want.normal_z, m_data.normal_z);
                        error_count++;
                    end
                end
            end
            if (recv_idle > 0) begin
                m_ready   <= 1'b0;
                recv_idle <= recv_idle - 1;
            end else if (pending_beats.size() > CalmTail && $urandom_range(0, 4) == 0) begin
                m_ready   <= 1'b0;
                recv_idle <= $urandom_range(0, 3);
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Reset, then wait for the stimulus to drain and the results to arrive.
    initial begin
        aresetn = 1'b0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        while (pending_beats.size() > 0 || s_valid) @(posedge aclk);
        while (expected_normals.size() > 0) @(posedge aclk);
        repeat (600) @(posedge aclk);
        $display("Covered %0d loads, %0d triangles, %0d reads and %0d ignored beats.",
                 load_count, tri_count, read_count, other_count);
        $display("Checked %0d normal results, %0d mismatches, %0d results missing.",
                 result_count, error_count, expected_normals.size());
        if (error_count == 0 && expected_normals.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    // Watchdog against a hung handshake.
    initial begin
        #20ms;
        $display("Timed out with %0d beats and %0d results outstanding.",
                 pending_beats.size(), expected_normals.size());
        $display("TEST FAILED");
        $finish;
    end

endmodule
